// File: rtl/core/uhk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uhk_pkg: shared types and constants for the hiragana-to-katakana converter
// Holds the result bundle, the state update bundle and the lead byte decoder.
// ----------------------------------------------------------------------------
package uhk_pkg;

	typedef logic [7:0] byte_t;

	// Up to four output bytes for one input byte, first byte in slot 0.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      cnt;
		logic            done;
	} res_t;

	// Next value of the sequence state after one input byte.
	typedef struct packed {
		logic       wr_pend;
		logic [1:0] wr_idx;
		logic [1:0] pcnt;
		logic [2:0] slen;
	} nxt_t;

	localparam logic [20:0] HiraLo   = 21'h03041;
	localparam logic [20:0] HiraHi   = 21'h03096;
	localparam logic [20:0] KataOfs  = 21'h00060;
	localparam logic [20:0] Max1Byte = 21'h0007F;
	localparam logic [20:0] Max2Byte = 21'h007FF;
	localparam logic [20:0] Max3Byte = 21'h0FFFF;

	// Expected sequence length from a lead byte; zero for an invalid lead.
	function automatic logic [2:0] lead_len(input byte_t b);
		logic [2:0] len;
		if (!b[7]) begin
			len = 3'd1;
		end else if (b[7:5] == 3'b110) begin
			len = 3'd2;
		end else if (b[7:4] == 4'b1110) begin
			len = 3'd3;
		end else if (b[7:3] == 5'b11110) begin
			len = 3'd4;
		end else begin
			len = 3'd0;
		end
		return len;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/uhk_conv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uhk_conv: per-byte conversion logic
// Decodes a completed sequence, shifts hiragana to katakana, re-encodes it,
// or builds the raw pass-through list; also works out the next state.
// ----------------------------------------------------------------------------
module uhk_conv (
	input  wire  uhk_pkg::byte_t         in_byte,
	input  wire  logic                   text_end,
	input  wire  logic [2:0][7:0]        pend,
	input  wire  logic [1:0]             pcnt,
	input  wire  logic [2:0]             slen,
	output uhk_pkg::res_t                res,
	output uhk_pkg::nxt_t                nxt
);
	import uhk_pkg::*;

	logic            open_seq;
	logic            cont;
	logic            complete;
	logic            grow;
	logic [2:0]      len;
	logic            single;
	logic            emit_b;
	logic [20:0]     cp;
	logic [20:0]     cpk;
	logic [3:0][7:0] enc;
	logic [2:0]      enc_cnt;
	logic [3:0][7:0] raw;
	logic [2:0]      raw_cnt;

	always_comb begin
		open_seq = (slen != 3'd0);
		cont     = (in_byte[7:6] == 2'b10);
		complete = open_seq && cont && (({1'b0, pcnt} + 3'd1) == slen);
		grow     = open_seq && cont && !complete;
		len      = lead_len(in_byte);
		single   = (len == 3'd0) || (len == 3'd1);

		unique case (slen)
			3'd2: cp = {10'd0, pend[0][4:0], in_byte[5:0]};
			3'd3: cp = {5'd0, pend[0][3:0], pend[1][5:0], in_byte[5:0]};
			default: cp = {pend[0][2:0], pend[1][5:0], pend[2][5:0], in_byte[5:0]};
		endcase

		cpk = ((cp >= HiraLo) && (cp <= HiraHi)) ? (cp + KataOfs) : cp;

		// Shortest encoding of the (possibly shifted) code point.
		enc = '0;
		if (cpk <= Max1Byte) begin
			enc_cnt = 3'd1;
			enc[0]  = cpk[7:0];
		end else if (cpk <= Max2Byte) begin
			enc_cnt = 3'd2;
			enc[0]  = {3'b110, cpk[10:6]};
			enc[1]  = {2'b10, cpk[5:0]};
		end else if (cpk <= Max3Byte) begin
			enc_cnt = 3'd3;
			enc[0]  = {4'b1110, cpk[15:12]};
			enc[1]  = {2'b10, cpk[11:6]};
			enc[2]  = {2'b10, cpk[5:0]};
		end else begin
			enc_cnt = 3'd4;
			enc[0]  = {5'b11110, cpk[20:18]};
			enc[1]  = {2'b10, cpk[17:12]};
			enc[2]  = {2'b10, cpk[11:6]};
			enc[3]  = {2'b10, cpk[5:0]};
		end

		// Raw list: buffered bytes in order, then the current byte if it goes out.
		raw[0] = (pcnt > 2'd0) ? pend[0] : in_byte;
		raw[1] = (pcnt > 2'd1) ? pend[1] : in_byte;
		raw[2] = (pcnt > 2'd2) ? pend[2] : in_byte;
		raw[3] = in_byte;
		emit_b = grow ? text_end : (single || text_end);
		if (grow) begin
			raw_cnt = text_end ? ({1'b0, pcnt} + 3'd1) : 3'd0;
		end else begin
			raw_cnt = {1'b0, pcnt} + {2'd0, emit_b};
		end

		res.bytes = complete ? enc : raw;
		res.cnt   = complete ? enc_cnt : raw_cnt;
		res.done  = text_end;

		// State update.
		nxt.wr_pend = grow || (!complete && !grow && !single);
		nxt.wr_idx  = grow ? pcnt : 2'd0;
		if (text_end || complete) begin
			nxt.pcnt = 2'd0;
			nxt.slen = 3'd0;
		end else if (grow) begin
			nxt.pcnt = pcnt + 2'd1;
			nxt.slen = slen;
		end else if (!single) begin
			nxt.pcnt = 2'd1;
			nxt.slen = len;
		end else begin
			nxt.pcnt = 2'd0;
			nxt.slen = 3'd0;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/uhk_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uhk_emit: result register and byte serialiser
// Holds the bytes of one input request and sends them out one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module uhk_emit (
	input  wire  logic          clk,
	input  wire  logic          arst_n,
	input  wire  logic          load,
	input  wire  uhk_pkg::res_t res,
	output logic                free,
	output logic                m_tvalid,
	input  wire  logic          m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tlast,
	output logic                m_tuser
);
	import uhk_pkg::*;

	logic [2:0]      cnt_q;
	logic            done_q;
	logic [3:0][7:0] data_q;
	logic            pop;

	assign pop      = m_tvalid && m_tready;
	assign free     = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && m_tready);
	assign m_tvalid = (cnt_q != 3'd0);
	assign m_tdata  = data_q[0];
	assign m_tlast  = (cnt_q == 3'd1);
	assign m_tuser  = (cnt_q == 3'd1) && done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 3'd0;
			done_q <= 1'b0;
		end else if (load) begin
			cnt_q  <= res.cnt;
			done_q <= res.done;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res.bytes;
		end else if (pop) begin
			data_q <= {8'h00, data_q[3:1]};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result count out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("result register loaded while bytes still pending");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (cnt_q == 3'd1) && !load) |=> (cnt_q == 3'd0))
		else $error("result register did not empty after last byte");

endmodule
`default_nettype wire

// File: rtl/core/utf8_hiragana_to_katakana.sv
// The first output byte is registered and shows in the cycle after its input is taken.
// Throughput: one input byte per cycle while each byte yields at most one result byte
// and the output is ready; a byte yielding more bytes holds the input until the single
// result register, which sends one byte per cycle while ready, is at its last byte.
// Reset: arst_n clears the sequence state and empties the result register at once.
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_hiragana_to_katakana: streaming UTF-8 hiragana to katakana shift
// Buffers multi-byte UTF-8 sequences, shifts code points U+3041..U+3096 up by
// 0x60 and re-encodes them in shortest form. Bytes that do not form a valid
// sequence pass through raw, and an unfinished sequence is flushed at the end
// of the text.
// ----------------------------------------------------------------------------
module utf8_hiragana_to_katakana (
	input  wire  logic       clk,
	input  wire  logic       arst_n,
	input  wire  logic       s_tvalid,
	output logic             s_tready,
	input  wire  logic [7:0] s_tdata,   // [7:0] in_byte
	input  wire  logic       s_tlast,   // text_end
	output logic             m_tvalid,
	input  wire  logic       m_tready,
	output logic [7:0]       m_tdata,   // [7:0] out_byte
	output logic             m_tlast,   // run_last
	output logic             m_tuser    // [0] text_done
);
	import uhk_pkg::*;

	// Sequence state. The pending bytes are only read below the pending count,
	// so they need no reset.
	logic [2:0][7:0] pend_q;
	logic [1:0]      pcnt_q;
	logic [2:0]      slen_q;

	res_t res;
	nxt_t nxt;
	logic take;
	logic free;

	// A request is taken whenever the result register is empty or about to be.
	assign s_tready = free;
	assign take     = s_tvalid && s_tready;

	uhk_conv u_conv (
		.in_byte  (s_tdata),
		.text_end (s_tlast),
		.pend     (pend_q),
		.pcnt     (pcnt_q),
		.slen     (slen_q),
		.res      (res),
		.nxt      (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= 2'd0;
			slen_q <= 3'd0;
		end else if (take) begin
			pcnt_q <= nxt.pcnt;
			slen_q <= nxt.slen;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (take && nxt.wr_pend && (nxt.wr_idx == 2'(i))) begin
				pend_q[i] <= s_tdata;
			end
		end
	end

	// Requests that only buffer a byte leave the result register untouched.
	uhk_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take && (res.cnt != 3'd0)),
		.res      (res),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// The pending count is zero exactly when no sequence is open.
	a_open_count: assert property (@(posedge clk) disable iff (!arst_n)
		(slen_q == 3'd0) == (pcnt_q == 2'd0))
		else $error("pending count and sequence length disagree");

	// An open sequence always still waits for at least one byte.
	a_pending_short: assert property (@(posedge clk) disable iff (!arst_n)
		(slen_q != 3'd0) |-> ({1'b0, pcnt_q} < slen_q))
		else $error("open sequence already complete");

	// After the final byte of a text no sequence stays open.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && s_tlast) |=> (slen_q == 3'd0))
		else $error("sequence left open after end of text");

endmodule
`default_nettype wire

// File: dv/kana_shift_checker.sv
// ----------------------------------------------------------------------------
// kana_shift_checker: scoreboard for the hiragana-to-katakana converter
// Watches both streams, predicts the output bytes of every accepted request
// and compares each accepted output byte with the oldest prediction.
// ----------------------------------------------------------------------------
module kana_shift_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	input  wire logic       s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_byte
	input  wire logic       s_tlast,   // text_end
	input  wire logic       m_tvalid,
	input  wire logic       m_tready,
	input  wire logic [7:0] m_tdata,   // [7:0] out_byte
	input  wire logic       m_tlast,   // run_last
	input  wire logic       m_tuser,   // [0] text_done
	output int              failures,
	output int              outstanding
);
	import uhk_pkg::*;

	typedef struct packed {
		byte_t data;
		logic  run_last;
		logic  text_done;
	} kana_out_t;

	kana_out_t  converted_q[$];
	byte_t      step_bytes[$];
	byte_t      held[3];
	logic [1:0] held_cnt;
	logic [2:0] seq_len;

	task automatic queue_byte(input byte_t v);
		step_bytes = {step_bytes, v};
	endtask

	task automatic flush_held();
		for (int k = 0; k < held_cnt; k++) begin
			queue_byte(held[k]);
		end
		held_cnt = '0;
		seq_len  = '0;
	endtask

	// Works out the output bytes caused by one input byte and queues them.
	task automatic predict_conversion(input byte_t b, input logic text_end);
		logic [20:0] cp;
		logic        fresh;
		kana_out_t   entry;
		fresh = 1'b1;
		step_bytes.delete();
		if (seq_len != 0) begin
			if (b[7:6] == 2'b10) begin
				fresh = 1'b0;
				if (held_cnt + 1 == seq_len) begin
					case (seq_len)
						3'd2:    cp = 21'(held[0][4:0]);
						3'd3:    cp = 21'(held[0][3:0]);
						default: cp = 21'(held[0][2:0]);
					endcase
					for (int k = 1; k < held_cnt; k++) begin
						cp = (cp << 6) | 21'(held[k][5:0]);
					end
					cp = (cp << 6) | 21'(b[5:0]);
					held_cnt = '0;
					seq_len  = '0;
					if (cp >= HiraLo && cp <= HiraHi) begin
						cp = cp + KataOfs;
					end
					if (cp <= Max1Byte) begin
						queue_byte(cp[7:0]);
					end else if (cp <= Max2Byte) begin
						queue_byte({3'b110, cp[10:6]});
						queue_byte({2'b10, cp[5:0]});
					end else if (cp <= Max3Byte) begin
						queue_byte({4'b1110, cp[15:12]});
						queue_byte({2'b10, cp[11:6]});
						queue_byte({2'b10, cp[5:0]});
					end else begin
						queue_byte({5'b11110, cp[20:18]});
						queue_byte({2'b10, cp[17:12]});
						queue_byte({2'b10, cp[11:6]});
						queue_byte({2'b10, cp[5:0]});
					end
				end else begin
					held[held_cnt] = b;
					held_cnt       = held_cnt + 2'd1;
				end
			end else begin
				// A broken sequence goes out raw; the byte then starts afresh.
				flush_held();
			end
		end
		if (fresh) begin
			if (!b[7]) begin
				queue_byte(b);
			end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
				held[0]  = b;
				held_cnt = 2'd1;
				seq_len  = b[5] ? (b[4] ? 3'd4 : 3'd3) : 3'd2;
			end else begin
				queue_byte(b);
			end
		end
		if (text_end && seq_len != 0) begin
			flush_held();
		end
		foreach (step_bytes[i]) begin
			entry = '{step_bytes[i], i == step_bytes.size() - 1,
				text_end && i == step_bytes.size() - 1};
			converted_q = {converted_q, entry};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		kana_out_t got;
		kana_out_t want;
		if (!arst_n) begin
			converted_q.delete();
			held_cnt    = '0;
			seq_len     = '0;
			failures    = 0;
			outstanding = 0;
		end else begin
			// Outputs come from a register that their request loaded, so settle them first.
			if (m_tvalid && m_tready) begin
				got = '{m_tdata, m_tlast, m_tuser};
				if (converted_q.size() == 0) begin
					if (failures < 10) begin
						$display("%0t: unexpected output byte %h last=%b done=%b",
							$realtime, got.data, got.run_last, got.text_done);
					end
					failures++;
				end else begin
					want = converted_q.pop_front();
					if (got !== want) begin
						if (failures < 10) begin
							$display("%0t: byte %h last=%b done=%b, expected %h last=%b done=%b",
								$realtime, got.data, got.run_last, got.text_done,
								want.data, want.run_last, want.text_done);
						end
						failures++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_conversion(s_tdata, s_tlast);
			end
			outstanding = converted_q.size();
		end
	end

endmodule

// File: dv/utf8_hiragana_to_katakana_test.sv
// ----------------------------------------------------------------------------
// utf8_hiragana_to_katakana_test: stream test of the kana converter
// Feeds directed and random UTF-8 text through the converter with random
// bursts on the input and a shifting stall pattern on the output, and leaves
// prediction and comparison to the scoreboard beside it.
// ----------------------------------------------------------------------------
module utf8_hiragana_to_katakana_test;
	import uhk_pkg::*;

	// The output side moves between a few flow regimes, each kept for a while,
	// so that free-flowing stretches alternate with light and heavy stalling.
	typedef enum logic [1:0] {
		FLOW_FREE,
		FLOW_COIN,
		FLOW_LIGHT,
		FLOW_HEAVY
	} flow_t;

	logic  clk      = 1'b0;
	logic  arst_n   = 1'b0;
	logic  s_tvalid = 1'b0;
	logic  s_tready;
	byte_t s_tdata  = '0;
	logic  s_tlast  = 1'b0;
	logic  m_tvalid;
	logic  m_tready = 1'b0;
	byte_t m_tdata;
	logic  m_tlast;
	logic  m_tuser;

	int    failures;
	int    outstanding;
	int    burst_left = 0;
	int    flow_left  = 0;
	flow_t flow       = FLOW_FREE;

	always #6 clk = ~clk;

	utf8_hiragana_to_katakana uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	kana_shift_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser),
		.failures    (failures),
		.outstanding (outstanding)
	);

	// Offers one request and returns at the falling edge after it is taken.
	// Requests go out in bursts of random length; between bursts the valid
	// line drops for a random gap, which may be empty, so gaps land anywhere
	// inside a multi-byte sequence as well as between characters. The valid
	// line is only lowered when a real gap follows, so it never drops and
	// rises within one step.
	task automatic send_request(input byte_t b, input logic text_end);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= text_end;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	function automatic byte_t cont_byte();
		return byte_t'(8'h80 | $urandom_range(0, 63));
	endfunction

	// The receiver stall pattern runs on its own, changed at the falling edge.
	always @(negedge clk) begin
		if (flow_left == 0) begin
			flow      = flow_t'($urandom_range(0, 3));
			flow_left = $urandom_range(8, 60);
		end
		flow_left--;
		case (flow)
			FLOW_FREE:  m_tready <= 1'b1;
			FLOW_COIN:  m_tready <= ($urandom_range(0, 1) == 1);
			FLOW_LIGHT: m_tready <= ($urandom_range(0, 4) != 0);
			FLOW_HEAVY: m_tready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	initial begin : stimulus
		byte_t text[$];
		int    pick;
		int    seq_len;
		int    random_sent;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Plain bytes at both ends of the single-byte range; the second also
		// closes a text on a byte that completes at once.
		send_request(8'h00, 1'b0);
		send_request(8'h7F, 1'b1);
		// Stray continuation byte and the top invalid lead pass through raw.
		send_request(8'h80, 1'b0);
		send_request(8'hFF, 1'b0);
		// First and last hiragana, which must move to katakana.
		send_request(8'hE3, 1'b0); send_request(8'h81, 1'b0); send_request(8'h81, 1'b0);
		send_request(8'hE3, 1'b0); send_request(8'h82, 1'b0); send_request(8'h96, 1'b0);
		// Code points just outside the hiragana block stay as they are.
		send_request(8'hE3, 1'b0); send_request(8'h81, 1'b0); send_request(8'h80, 1'b0);
		send_request(8'hE3, 1'b0); send_request(8'h82, 1'b0); send_request(8'h97, 1'b0);
		// An overlong zero comes back in its shortest, single-byte form.
		send_request(8'hC0, 1'b0); send_request(8'h80, 1'b0);
		// The largest four-byte value, beyond the Unicode range.
		send_request(8'hF7, 1'b0); send_request(8'hBF, 1'b0);
		send_request(8'hBF, 1'b0); send_request(8'hBF, 1'b0);
		// A broken sequence: the lead goes out raw and the ASCII byte follows.
		send_request(8'hE3, 1'b0); send_request(8'h41, 1'b0);
		// A broken sequence whose breaking byte is itself a lead and also the
		// end of the text, so both leads are flushed raw in one request.
		send_request(8'hE3, 1'b0); send_request(8'hC3, 1'b1);

		// Random texts, mostly well-formed characters with random content and
		// a bias towards the hiragana block, mixed with truncated sequences
		// and raw noise. A truncated sequence at the end of a text exercises
		// the end-of-text flush.
		random_sent = 0;
		while (random_sent < 220) begin
			text.delete();
			repeat ($urandom_range(1, 12)) begin
				pick = $urandom_range(0, 99);
				if (pick < 25) begin
					text = {text, byte_t'($urandom_range(0, 127))};
				end else if (pick < 35) begin
					text = {text, byte_t'(8'hC0 | $urandom_range(0, 31))};
					text = {text, cont_byte()};
				end else if (pick < 60) begin
					// Around U+3000..U+30FF, covering the hiragana block edges.
					text = {text, byte_t'(8'hE3)};
					text = {text, byte_t'(8'h80 | $urandom_range(0, 3))};
					text = {text, cont_byte()};
				end else if (pick < 70) begin
					text = {text, byte_t'(8'hE0 | $urandom_range(0, 15))};
					text = {text, cont_byte()};
					text = {text, cont_byte()};
				end else if (pick < 78) begin
					text = {text, byte_t'(8'hF0 | $urandom_range(0, 7))};
					repeat (3) text = {text, cont_byte()};
				end else if (pick < 90) begin
					seq_len = $urandom_range(2, 4);
					case (seq_len)
						2:       text = {text, byte_t'(8'hC0 | $urandom_range(0, 31))};
						3:       text = {text, byte_t'(8'hE0 | $urandom_range(0, 15))};
						default: text = {text, byte_t'(8'hF0 | $urandom_range(0, 7))};
					endcase
					repeat ($urandom_range(0, seq_len - 2)) text = {text, cont_byte()};
				end else begin
					text = {text, byte_t'($urandom_range(0, 255))};
				end
			end
			foreach (text[i]) begin
				send_request(text[i], i == text.size() - 1);
			end
			random_sent += text.size();
		end
		s_tvalid <= 1'b0;

		// Drain: wait for every predicted byte, then a while longer so that
		// any stray extra output is caught by the scoreboard.
		while (outstanding != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (failures == 0 && outstanding == 0) begin
			$display("utf8_hiragana_to_katakana test passed");
		end else begin
			$display("utf8_hiragana_to_katakana test failed");
		end
		$finish;
	end

	// Some 300 requests of at most four output bytes each, every byte facing
	// the longest stall, finish well inside a tenth of this time.
	initial begin : watchdog
		#4000000;
		$display("utf8_hiragana_to_katakana test failed");
		$finish;
	end

endmodule
